[hdl/rekd_pkg.sv]
// ----------------------------------------------------------------------------
// rekd_pkg
// Shared widths, codes and types of the rotary encoder and key decoder.
// ----------------------------------------------------------------------------
package rekd_pkg;

  // Width of the wrapping rotation counter.
  localparam int COUNT_WIDTH = 16;
  // Width over which tick differences wrap.
  localparam int TICK_WIDTH = 32;

  // Payload widths on the ports.
  localparam int NOW_WIDTH     = 32;
  localparam int THRESH_WIDTH  = 16;
  localparam int POS_WIDTH     = 16;
  localparam int IN_DATA_WIDTH = 40;
  localparam int OUT_DATA_WIDTH = 24;
  localparam int ADDR_WIDTH    = 4;
  localparam int REG_WIDTH     = 32;

  // Configuration register indexes (byte address / 4).
  localparam logic [1:0] REG_DIRECTION  = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_MIN_PRESS  = 2'd2;

  // Register reset values.
  localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET = THRESH_WIDTH'(100);
  localparam logic [THRESH_WIDTH-1:0] MIN_PRESS_RESET  = THRESH_WIDTH'(10);

  // Event kinds carried in tuser.
  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_KEY  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // Rotation seen since the last read.
  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_UP   = 2'd1,
    ROT_DOWN = 2'd2
  } rot_t;

  // Key machine, one-hot.
  typedef enum logic [3:0] {
    KEY_IDLE    = 4'b0001,
    KEY_PRESSED = 4'b0010,
    KEY_SHORT   = 4'b0100,
    KEY_LONG    = 4'b1000
  } key_state_t;

  // Key phase codes as reported on the result.
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_PRESSED = 2'd1;
  localparam logic [1:0] PHASE_SHORT   = 2'd2;
  localparam logic [1:0] PHASE_LONG    = 2'd3;

  // Base values of the combined code for each key phase.
  localparam logic [3:0] COMB_BASE_NONE  = 4'd0;
  localparam logic [3:0] COMB_BASE_SHORT = 4'd3;
  localparam logic [3:0] COMB_BASE_LONG  = 4'd6;
  localparam logic [3:0] COMB_OFS_UP     = 4'd1;
  localparam logic [3:0] COMB_OFS_DOWN   = 4'd2;

endpackage

[hdl/rotary_encoder_key_decoder.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_key_decoder
// Each accepted item's result is loaded into the output register.
// Throughput: one item per cycle unless m_tready stalls the output; the output register frees while it is taken.
// Each item is decoded in one pass of short logic from the port to the state.
// Reset (synchronous, active high) clears the decoder state and the output valid flag and loads register defaults.
// ----------------------------------------------------------------------------
module rotary_encoder_key_decoder (
  input  logic                                clk,
  input  logic                                rst,
  // Event item input.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: a_level[0], b_level[1], key_level[2], now_tick[34:3], zero[39:35]
  input  logic [rekd_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  // s_tuser: op[1:0]
  input  logic [1:0]                          s_tuser,
  // Result item output.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: combined_state[3:0], position[19:4], key_phase[21:20], zero[23:22]
  output logic [rekd_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rekd_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [rekd_pkg::REG_WIDTH-1:0]      pwdata,
  output logic [rekd_pkg::REG_WIDTH-1:0]      prdata,
  output logic                                pready
);
  import rekd_pkg::*;

  // Configuration registers.
  logic                    direction;
  logic [THRESH_WIDTH-1:0] long_press_ticks;
  logic [THRESH_WIDTH-1:0] min_press_ticks;

  // Decoder state.
  logic                   capture_pending, capture_pending_next;
  logic                   latched_b, latched_b_next;
  logic [COUNT_WIDTH-1:0] counter, counter_next;
  rot_t                   pending_rotation, pending_rotation_next;
  key_state_t             key_machine, key_machine_next;
  logic [TICK_WIDTH-1:0]  press_start_tick, press_start_tick_next;
  logic [3:0]             last_combined, last_combined_next;

  // Unpacked input fields.
  op_t                    op;
  logic                   a_level;
  logic                   b_level;
  logic                   key_level;
  logic [NOW_WIDTH-1:0]   now_tick;
  logic [TICK_WIDTH-1:0]  now_t;
  logic [TICK_WIDTH-1:0]  held;
  logic                   held_long;
  logic                   held_min;
  logic                   step_up;
  logic                   step_dn;
  logic                   in_accept;
  logic                   cfg_write;
  logic [1:0]             reg_index;
  logic [3:0]             comb_base;
  logic [31:0]            pos_ext;
  logic [1:0]             key_phase_next;

  // Output register.
  logic [3:0]             out_combined;
  logic [POS_WIDTH-1:0]   out_position;
  logic [1:0]             out_phase;

  assign op        = op_t'(s_tuser);
  assign a_level   = s_tdata[0];
  assign b_level   = s_tdata[1];
  assign key_level = s_tdata[2];
  assign now_tick  = s_tdata[NOW_WIDTH+2:3];
  assign now_t     = now_tick[TICK_WIDTH-1:0];

  // The input is taken whenever the output register is empty or being drained.
  assign s_tready  = ~m_tvalid | m_tready;
  assign in_accept = s_tvalid & s_tready;

  // Held time wraps over the tick width; thresholds compare at a common width.
  assign held      = now_t - press_start_tick;
  assign held_long = 32'(held) >= 32'(long_press_ticks);
  assign held_min  = 32'(held) >= 32'(min_press_ticks);

  // Quadrature step decision on a finished capture.
  assign step_up = (latched_b & ~b_level & ~direction) | (~latched_b & b_level & direction);
  assign step_dn = (latched_b & ~b_level & direction) | (~latched_b & b_level & ~direction);

  // Next state for one event.
  always_comb begin
    capture_pending_next  = capture_pending;
    latched_b_next        = latched_b;
    counter_next          = counter;
    pending_rotation_next = pending_rotation;
    key_machine_next      = key_machine;
    press_start_tick_next = press_start_tick;
    last_combined_next    = last_combined;
    comb_base             = COMB_BASE_NONE;
    unique case (op)
      OP_EDGE: begin
        if (!a_level && !capture_pending) begin
          capture_pending_next = 1'b1;
          latched_b_next       = b_level;
        end else if (a_level && capture_pending) begin
          capture_pending_next = 1'b0;
          if (step_up) begin
            counter_next          = counter + COUNT_WIDTH'(1);
            pending_rotation_next = ROT_UP;
          end else if (step_dn) begin
            counter_next          = counter - COUNT_WIDTH'(1);
            pending_rotation_next = ROT_DOWN;
          end
        end
      end
      OP_KEY: begin
        if (!key_level) begin
          // Key held down.
          if (key_machine == KEY_IDLE) begin
            key_machine_next      = KEY_PRESSED;
            press_start_tick_next = now_t;
          end else if (key_machine == KEY_PRESSED && held_long) begin
            key_machine_next = KEY_LONG;
          end
        end else begin
          // Key released.
          if (key_machine == KEY_PRESSED) begin
            if (held_long) begin
              key_machine_next = KEY_LONG;
            end else if (held_min) begin
              key_machine_next = KEY_SHORT;
            end
          end else begin
            key_machine_next      = KEY_IDLE;
            press_start_tick_next = now_t;
          end
        end
      end
      OP_READ: begin
        pending_rotation_next = ROT_NONE;
        if (key_machine == KEY_SHORT) begin
          comb_base = COMB_BASE_SHORT;
        end else if (key_machine == KEY_LONG) begin
          comb_base = COMB_BASE_LONG;
        end
        unique case (pending_rotation)
          ROT_UP:   last_combined_next = comb_base + COMB_OFS_UP;
          ROT_DOWN: last_combined_next = comb_base + COMB_OFS_DOWN;
          default:  last_combined_next = comb_base;
        endcase
      end
      default: begin
        // Unused event kind: nothing changes.
      end
    endcase
  end

  // Result fields formed from the state after the event.
  assign pos_ext = 32'(signed'(counter_next));

  always_comb begin
    unique case (key_machine_next)
      KEY_PRESSED: key_phase_next = PHASE_PRESSED;
      KEY_SHORT:   key_phase_next = PHASE_SHORT;
      KEY_LONG:    key_phase_next = PHASE_LONG;
      default:     key_phase_next = PHASE_IDLE;
    endcase
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_pending  <= 1'b0;
      latched_b        <= 1'b0;
      counter          <= '0;
      pending_rotation <= ROT_NONE;
      key_machine      <= KEY_IDLE;
      press_start_tick <= '0;
      last_combined    <= COMB_BASE_NONE;
    end else if (in_accept) begin
      capture_pending  <= capture_pending_next;
      latched_b        <= latched_b_next;
      counter          <= counter_next;
      pending_rotation <= pending_rotation_next;
      key_machine      <= key_machine_next;
      press_start_tick <= press_start_tick_next;
      last_combined    <= last_combined_next;
    end
  end

  // Output register: valid flag under reset, payload loaded on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_combined <= last_combined_next;
      out_position <= pos_ext[POS_WIDTH-1:0];
      out_phase    <= key_phase_next;
    end
  end

  assign m_tdata = {2'b00, out_phase, out_position, out_combined};

  // Configuration port: writes complete in the access cycle.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction        <= 1'b0;
      long_press_ticks <= LONG_PRESS_RESET;
      min_press_ticks  <= MIN_PRESS_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_DIRECTION:  direction        <= pwdata[0];
        REG_LONG_PRESS: long_press_ticks <= pwdata[THRESH_WIDTH-1:0];
        REG_MIN_PRESS:  min_press_ticks  <= pwdata[THRESH_WIDTH-1:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_index)
      REG_DIRECTION:  prdata = {31'd0, direction};
      REG_LONG_PRESS: prdata = REG_WIDTH'(long_press_ticks);
      REG_MIN_PRESS:  prdata = REG_WIDTH'(min_press_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotary encoder and push key decoder. Items are
// driven on the input stream and every result is compared field by field with
// a local model of the decoder or a directed row's own expected result. The run
// steps through several register settings, idling and stalling on both streams,
// and walks the rotation counter across zero in both directions.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rekd_pkg::*;

  // Event code that the decoder ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Register index past the last register.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // The run is ended after this many nanoseconds.
  localparam int TIMEOUT_NS = 10_000_000;

  typedef struct packed {
    logic [3:0]                  combined;
    logic signed [POS_WIDTH-1:0] position;
    logic [1:0]                  phase;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    logic        a;
    logic        b;
    logic        key;
    logic [31:0] now;
    bit          typed;
    result_t     exp;
  } row_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  // s_tdata: a_level[0], b_level[1], key_level[2], now_tick[34:3], zero[39:35]
  logic [IN_DATA_WIDTH-1:0]  s_tdata;
  // s_tuser: op[1:0]
  logic [1:0]                s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  // m_tdata: combined_state[3:0], position[19:4], key_phase[21:20], zero[23:22]
  logic [OUT_DATA_WIDTH-1:0] m_tdata;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_WIDTH-1:0]     paddr;
  logic [REG_WIDTH-1:0]      pwdata;
  logic [REG_WIDTH-1:0]      prdata;
  logic                      pready;

  rotary_encoder_key_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Decoder model: register copies and state.
  logic                   dir_cfg;
  logic [THRESH_WIDTH-1:0] long_cfg;
  logic [THRESH_WIDTH-1:0] min_cfg;
  logic                   cap_pending;
  logic                   latch_b;
  logic [COUNT_WIDTH-1:0] count_q;
  rot_t                   rot_pend;
  logic [1:0]             phase_q;
  logic [TICK_WIDTH-1:0]  press_tick;
  logic [3:0]             last_code;

  result_t expected_reports[$];
  row_t    directed_rows[$];
  int      mismatch_count;

  // Bench controls shared between the processes.
  int          idle_pct;
  int          stall_pct;
  int          hold_off_req;
  int          hold_left;
  bit          offer_typed;
  result_t     offer_exp;
  logic [31:0] scan_tick;
  bit          key_held;

  // Applies one event to the model and returns the result it produces.
  function automatic result_t decode_event(logic [1:0] op, logic a, logic b,
                                           logic key, logic [31:0] now);
    logic [TICK_WIDTH-1:0] held;
    logic                  up;
    logic [3:0]            base;
    result_t               r;
    held = now - press_tick;
    case (op)
      OP_EDGE: begin
        if (!a && !cap_pending) begin
          cap_pending = 1'b1;
          latch_b = b;
        end else if (a && cap_pending) begin
          cap_pending = 1'b0;
          // A change of B between the two A edges steps the counter.
          if (latch_b != b) begin
            up = latch_b ^ dir_cfg;
            count_q = up ? count_q + 1'b1 : count_q - 1'b1;
            rot_pend = up ? ROT_UP : ROT_DOWN;
          end
        end
      end
      OP_KEY: begin
        if (!key) begin
          if (phase_q == PHASE_IDLE) begin
            phase_q = PHASE_PRESSED;
            press_tick = now;
          end else if (phase_q == PHASE_PRESSED && held >= long_cfg) begin
            phase_q = PHASE_LONG;
          end
        end else begin
          if (phase_q == PHASE_PRESSED) begin
            if (held >= long_cfg) phase_q = PHASE_LONG;
            else if (held >= min_cfg) phase_q = PHASE_SHORT;
          end else begin
            phase_q = PHASE_IDLE;
            press_tick = now;
          end
        end
      end
      OP_READ: begin
        case (phase_q)
          PHASE_SHORT: base = COMB_BASE_SHORT;
          PHASE_LONG:  base = COMB_BASE_LONG;
          default:     base = COMB_BASE_NONE;
        endcase
        if (rot_pend == ROT_UP) last_code = base + COMB_OFS_UP;
        else if (rot_pend == ROT_DOWN) last_code = base + COMB_OFS_DOWN;
        else last_code = base;
        rot_pend = ROT_NONE;
      end
      default: ;
    endcase
    r.combined = last_code;
    r.position = count_q;
    r.phase = phase_q;
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("testbench: FAIL");
    $finish;
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req != 0) begin
        hold_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor: predict each accepted item and check each accepted result.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.combined = m_tdata[3:0];
        got.position = m_tdata[19:4];
        got.phase = m_tdata[21:20];
        if (expected_reports.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: result with no item outstanding: combined %0d position %0d phase %0d",
                   $time, got.combined, got.position, got.phase);
        end else begin
          want = expected_reports.pop_front();
          if (got.combined !== want.combined) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: combined_state expected %0d, actual %0d",
                     $time, want.combined, got.combined);
          end
          if (got.position !== want.position) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: position expected %0d, actual %0d",
                     $time, want.position, got.position);
          end
          if (got.phase !== want.phase) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: key_phase expected %0d, actual %0d",
                     $time, want.phase, got.phase);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = decode_event(s_tuser, s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[34:3]);
        expected_reports.push_back(offer_typed ? offer_exp : want);
      end
    end
  end

  // Offers one item, after random idle cycles, and waits until it is taken.
  task automatic send_item(logic [1:0] op, logic a, logic b, logic key,
                           logic [31:0] now, bit typed, result_t exp);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {5'd0, now, key, b, a};
    offer_typed <= typed;
    offer_exp <= exp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_DIRECTION:  dir_cfg = value[0];
      REG_LONG_PRESS: long_cfg = value[THRESH_WIDTH-1:0];
      REG_MIN_PRESS:  min_cfg = value[THRESH_WIDTH-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Writes all three registers; the upper data bits are random filler.
  task automatic configure(logic dir, logic [15:0] long_ticks, logic [15:0] min_ticks);
    write_reg(REG_DIRECTION, {31'($urandom_range(32'h7FFF_FFFF)), dir});
    write_reg(REG_LONG_PRESS, {16'($urandom_range(16'hFFFF)), long_ticks});
    write_reg(REG_MIN_PRESS, {16'($urandom_range(16'hFFFF)), min_ticks});
  endtask

  // Random items, mostly well-formed encoder detents and key sequences.
  task automatic run_random(int n_items, int idle, int stall);
    int      sent;
    int      kind;
    int      span;
    logic    b0;
    result_t none;
    none = '0;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        // One detent: falling A latches B, rising A usually sees B flipped.
        b0 = 1'($urandom_range(1));
        send_item(OP_EDGE, 1'b0, b0, 1'($urandom_range(1)), $urandom, 1'b0, none);
        send_item(OP_EDGE, 1'b1, ($urandom_range(3) == 0) ? b0 : ~b0,
                  1'($urandom_range(1)), $urandom, 1'b0, none);
        sent = sent + 2;
      end else if (kind < 60) begin
        // Key scan with a tick that mostly advances in steps of up to about a third of the larger threshold.
        if ($urandom_range(3) == 0) key_held = ~key_held;
        span = ((long_cfg > min_cfg) ? long_cfg : min_cfg) / 3 + 2;
        if ($urandom_range(15) == 0) scan_tick = $urandom;
        else scan_tick = scan_tick + $urandom_range(span);
        send_item(OP_KEY, 1'($urandom_range(1)), 1'($urandom_range(1)), ~key_held,
                  scan_tick, 1'b0, none);
        sent = sent + 1;
      end else if (kind < 80) begin
        send_item(OP_READ, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom, 1'b0, none);
        sent = sent + 1;
      end else if (kind < 93) begin
        send_item(OP_EDGE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom, 1'b0, none);
        sent = sent + 1;
      end else begin
        send_item(OP_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom, 1'b0, none);
        sent = sent + 1;
      end
    end
  endtask

  // Main sequence.
  initial begin
    result_t none;
    none = '0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    offer_typed = 1'b0;
    offer_exp = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off_req = 0;
    mismatch_count = 0;
    scan_tick = '0;
    key_held = 1'b0;
    dir_cfg = 1'b0;
    long_cfg = LONG_PRESS_RESET;
    min_cfg = MIN_PRESS_RESET;
    cap_pending = 1'b0;
    latch_b = 1'b0;
    count_q = '0;
    rot_pend = ROT_NONE;
    phase_q = PHASE_IDLE;
    press_tick = '0;
    last_code = COMB_BASE_NONE;

    // Directed items under the reset register values.
    directed_rows.push_back('{OP_READ, 1'b0, 1'b0, 1'b1, 32'h0, 1'b1,
                              '{4'd0, 16'sd0, PHASE_IDLE}});
    // The unused event code changes nothing.
    directed_rows.push_back('{OP_UNUSED, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,
                              '{4'd0, 16'sd0, PHASE_IDLE}});
    // Rising A with no capture pending is ignored.
    directed_rows.push_back('{OP_EDGE, 1'b1, 1'b0, 1'b1, 32'h0, 1'b1,
                              '{4'd0, 16'sd0, PHASE_IDLE}});
    directed_rows.push_back('{OP_EDGE, 1'b0, 1'b1, 1'b1, 32'h0, 1'b1,
                              '{4'd0, 16'sd0, PHASE_IDLE}});
    // A second falling A keeps the first latched B.
    directed_rows.push_back('{OP_EDGE, 1'b0, 1'b0, 1'b1, 32'h0, 1'b1,
                              '{4'd0, 16'sd0, PHASE_IDLE}});
    directed_rows.push_back('{OP_EDGE, 1'b1, 1'b0, 1'b1, 32'h0, 1'b1,
                              '{4'd0, 16'sd1, PHASE_IDLE}});
    directed_rows.push_back('{OP_READ, 1'b0, 1'b0, 1'b1, 32'h0, 1'b1,
                              '{4'd1, 16'sd1, PHASE_IDLE}});
    directed_rows.push_back('{OP_EDGE, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, none});
    directed_rows.push_back('{OP_EDGE, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, none});
    // A capture that ends with B unchanged does not count.
    directed_rows.push_back('{OP_EDGE, 1'b0, 1'b1, 1'b1, 32'h0, 1'b0, none});
    directed_rows.push_back('{OP_EDGE, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0, none});
    // Short press across the tick wrap.
    directed_rows.push_back('{OP_KEY, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b1, 32'h0000_0005, 1'b0, none});
    directed_rows.push_back('{OP_READ, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b1, 32'd6, 1'b0, none});
    // Release too early stays pressed, then the hold turns long.
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b0, 32'd1000, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b1, 32'd1003, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b0, 32'd1100, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, none});
    directed_rows.push_back('{OP_READ, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b1, 32'd99, 1'b0, none});
    directed_rows.push_back('{OP_READ, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, none});
    directed_rows.push_back('{OP_KEY, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0, none});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].key, directed_rows[i].now, directed_rows[i].typed,
                directed_rows[i].exp);
    drain();

    // Counter walk: down below zero, then up past zero into positive values.
    for (int i = 0; i < 10; i++) begin
      send_item(OP_EDGE, 1'b0, 1'b0, 1'b1, $urandom, 1'b0, none);
      send_item(OP_EDGE, 1'b1, 1'b1, 1'b1, $urandom, 1'b0, none);
    end
    for (int i = 0; i < 20; i++) begin
      send_item(OP_EDGE, 1'b0, 1'b1, 1'b0, $urandom, 1'b0, none);
      send_item(OP_EDGE, 1'b1, 1'b0, 1'b0, $urandom, 1'b0, none);
    end
    drain();

    // Reversed sense, thresholds of one and zero, no idling; a long receiver hold-off.
    configure(1'b1, 16'd1, 16'd0);
    run_random(100, 0, 0);
    hold_off_req = 400;
    run_random(100, 0, 0);
    drain();

    // Largest thresholds, a short press cannot happen; sender idles.
    configure(1'b0, 16'hFFFF, 16'hFFFF);
    run_random(200, 51, 0);
    drain();

    // A zero long threshold; the unused register is written too; receiver stalls.
    configure(1'b1, 16'd0, 16'd5);
    write_reg(REG_UNUSED, $urandom);
    run_random(200, 0, 51);
    drain();

    // Reset values again; both sides idle, with a pause until all results are in.
    configure(1'b0, LONG_PRESS_RESET, MIN_PRESS_RESET);
    run_random(100, 16, 16);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    run_random(100, 16, 16);
    drain();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
